### rtl/jsesc_pkg.sv
// Shared types, constants and the character classifier for the JSON string escaper.
`timescale 1ns / 1ps
`default_nettype none

package jsesc_pkg;

    localparam int unsigned CP_W      = 21;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned MAX_BYTES = 6;
    localparam int unsigned LEN_W     = $clog2(MAX_BYTES + 1);
    localparam int unsigned IDX_W     = $clog2(MAX_BYTES);
    localparam int unsigned Q_DEPTH   = 4;
    localparam int unsigned QPTR_W    = $clog2(Q_DEPTH);
    localparam int unsigned QCNT_W    = $clog2(Q_DEPTH + 1);

    localparam logic [CP_W-1:0]   CTRL_LIMIT  = 21'h00020;
    localparam logic [CP_W-1:0]   ASCII_LIMIT = 21'h00080;
    localparam logic [CP_W-1:0]   TWO_LIMIT   = 21'h00800;
    localparam logic [CP_W-1:0]   THREE_LIMIT = 21'h10000;
    localparam logic [CP_W-1:0]   MAX_SCALAR  = 21'h10FFFF;

    localparam logic [BYTE_W-1:0] CH_QMARK  = 8'h3F;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_BS     = 8'h08;
    localparam logic [BYTE_W-1:0] CH_FF     = 8'h0C;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LOW_B  = 8'h62;
    localparam logic [BYTE_W-1:0] CH_LOW_F  = 8'h66;
    localparam logic [BYTE_W-1:0] CH_LOW_N  = 8'h6E;
    localparam logic [BYTE_W-1:0] CH_LOW_R  = 8'h72;
    localparam logic [BYTE_W-1:0] CH_LOW_T  = 8'h74;
    localparam logic [BYTE_W-1:0] CH_LOW_U  = 8'h75;
    localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CH_LOW_A  = 8'h61;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            decode_failed;
    } t_in_req;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_byte;
    } t_out_req;

    // One classified character: its bytes in send order (entry 0 first) and count.
    typedef struct packed {
        logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
        logic [LEN_W-1:0]                 len;
    } t_seq;

    // Queue status seen by the two sides.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] nib);
        logic [BYTE_W-1:0] d;
        if (nib < 4'd10) begin
            d = CH_ZERO + {4'd0, nib};
        end else begin
            d = CH_LOW_A + {4'd0, nib} - 8'd10;
        end
        return d;
    endfunction

    function automatic t_seq classify(input t_in_req r);
        t_seq            s;
        logic [CP_W-1:0] cp;
        s.bytes = '0;
        s.len   = LEN_W'(1);
        cp      = r.code_point;
        if (r.decode_failed || cp > MAX_SCALAR) begin
            s.bytes[0] = CH_QMARK;
        end else if (cp < ASCII_LIMIT) begin
            unique case (cp[BYTE_W-1:0]) inside
                CH_QUOTE, CH_BSLASH, CH_SLASH: begin
                    s.bytes[0] = CH_BSLASH;
                    s.bytes[1] = cp[BYTE_W-1:0];
                    s.len      = LEN_W'(2);
                end
                CH_BS: begin
                    s.bytes[0] = CH_BSLASH; s.bytes[1] = CH_LOW_B; s.len = LEN_W'(2);
                end
                CH_FF: begin
                    s.bytes[0] = CH_BSLASH; s.bytes[1] = CH_LOW_F; s.len = LEN_W'(2);
                end
                CH_LF: begin
                    s.bytes[0] = CH_BSLASH; s.bytes[1] = CH_LOW_N; s.len = LEN_W'(2);
                end
                CH_CR: begin
                    s.bytes[0] = CH_BSLASH; s.bytes[1] = CH_LOW_R; s.len = LEN_W'(2);
                end
                CH_TAB: begin
                    s.bytes[0] = CH_BSLASH; s.bytes[1] = CH_LOW_T; s.len = LEN_W'(2);
                end
                default: begin
                    if (cp < CTRL_LIMIT) begin
                        s.bytes[0] = CH_BSLASH;
                        s.bytes[1] = CH_LOW_U;
                        s.bytes[2] = CH_ZERO;
                        s.bytes[3] = CH_ZERO;
                        s.bytes[4] = hex_digit(cp[7:4]);
                        s.bytes[5] = hex_digit(cp[3:0]);
                        s.len      = LEN_W'(6);
                    end else begin
                        s.bytes[0] = cp[BYTE_W-1:0];
                    end
                end
            endcase
        end else if (cp < TWO_LIMIT) begin
            s.bytes[0] = {3'b110, cp[10:6]};
            s.bytes[1] = {2'b10, cp[5:0]};
            s.len      = LEN_W'(2);
        end else if (cp < THREE_LIMIT) begin
            s.bytes[0] = {4'b1110, cp[15:12]};
            s.bytes[1] = {2'b10, cp[11:6]};
            s.bytes[2] = {2'b10, cp[5:0]};
            s.len      = LEN_W'(3);
        end else begin
            s.bytes[0] = {5'b11110, cp[20:18]};
            s.bytes[1] = {2'b10, cp[17:12]};
            s.bytes[2] = {2'b10, cp[11:6]};
            s.bytes[3] = {2'b10, cp[5:0]};
            s.len      = LEN_W'(4);
        end
        return s;
    endfunction

endpackage

`default_nettype wire

### rtl/jsesc_front.sv
// Front stage: takes input requests and registers their classified byte sequence.
`timescale 1ns / 1ps
`default_nettype none

module jsesc_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  push,
    output logic                 full,
    input  jsesc_pkg::t_in_req   i_in,
    input  jsesc_pkg::t_q_stat   i_q_stat,
    output logic                 o_q_push,
    output jsesc_pkg::t_seq      o_seq
);

    logic            r_valid;
    logic            n_valid;
    jsesc_pkg::t_seq r_seq;
    logic            take;

    assign full     = r_valid && i_q_stat.full;
    assign take     = push && !full;
    assign o_q_push = r_valid && !i_q_stat.full;
    assign o_seq    = r_seq;
    assign n_valid  = take || (r_valid && i_q_stat.full);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (take) begin
            r_seq <= jsesc_pkg::classify(i_in);
        end
    end

endmodule

`default_nettype wire

### rtl/jsesc_queue.sv
// Short queue of classified characters between the front and back stages.
`timescale 1ns / 1ps
`default_nettype none

module jsesc_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  jsesc_pkg::t_seq     i_seq,
    input  wire                 i_pop,
    output jsesc_pkg::t_seq     o_seq,
    output jsesc_pkg::t_q_stat  o_stat
);

    jsesc_pkg::t_seq                   r_mem [jsesc_pkg::Q_DEPTH];
    logic [jsesc_pkg::QPTR_W-1:0]      r_wr_ptr;
    logic [jsesc_pkg::QPTR_W-1:0]      r_rd_ptr;
    logic [jsesc_pkg::QCNT_W-1:0]      r_count;
    logic                              do_push;
    logic                              do_pop;

    assign o_stat.full  = (r_count == jsesc_pkg::QCNT_W'(jsesc_pkg::Q_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_seq        = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_seq;
        end
    end

endmodule

`default_nettype wire

### rtl/jsesc_back.sv
// Back stage: serializes one byte a cycle, while the output is taken, into the result output register.
`timescale 1ns / 1ps
`default_nettype none

module jsesc_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  jsesc_pkg::t_seq      i_seq,
    input  jsesc_pkg::t_q_stat   i_q_stat,
    output logic                 o_q_pop,
    output logic                 empty,
    input  wire                  pop,
    output jsesc_pkg::t_out_req  o_out
);

    logic                          r_ovalid;
    jsesc_pkg::t_out_req           r_out;
    logic [jsesc_pkg::IDX_W-1:0]   r_idx;
    logic                          load;
    logic                          is_last;

    assign empty   = !r_ovalid;
    assign o_out   = r_out;
    assign load    = !i_q_stat.empty && (!r_ovalid || pop);
    assign is_last = (r_idx == jsesc_pkg::IDX_W'(i_seq.len - 1'b1));
    assign o_q_pop = load && is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_idx    <= '0;
        end else begin
            if (load) begin
                r_ovalid <= 1'b1;
                r_idx    <= is_last ? '0 : r_idx + 1'b1;
            end else if (pop) begin
                r_ovalid <= 1'b0;
            end
        end
        if (load) begin
            r_out.out_byte  <= i_seq.bytes[r_idx];
            r_out.last_byte <= is_last;
        end
    end

endmodule

`default_nettype wire

### rtl/json_string_escape_utf8.sv
// Top level of the JSON string escaper with UTF-8 output.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   Input side is a queue write port: drive i_in (code point plus decode-failed
//   flag) and raise push; the request is taken on an edge where full is low.
//   Output side is a queue read port: while empty is low, o_out shows the
//   oldest byte (out_byte, last_byte); it is taken on an edge with pop high.
//   Each character gives 1 to 6 bytes; last_byte marks the final one.
// Path: a taken request passes the front register, the character queue and the
//   output register, in that order, before its first byte shows on o_out.
// Throughput: one byte per cycle at the output while pop is high; the output
//   register is the limit, as it sends each character one byte at a time. A new
//   request is taken every cycle while the four-entry character queue has room.
// Stall: if pop stays low the byte on o_out holds; the queue fills and full
//   rises, blocking new requests without losing any.
// Reset: synchronous, active low; clears front, queue and output valid state.
//   Both sides show empty / not full once reset has been sampled asserted.
module json_string_escape_utf8 (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  push,
    output logic                 full,
    input  jsesc_pkg::t_in_req   i_in,
    output logic                 empty,
    input  wire                  pop,
    output jsesc_pkg::t_out_req  o_out
);

    jsesc_pkg::t_seq     front_seq;
    jsesc_pkg::t_seq     q_seq;
    jsesc_pkg::t_q_stat  q_stat;
    logic                q_push;
    logic                q_pop;

    // Classify each character into its byte sequence
    jsesc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_in     (i_in),
        .i_q_stat (q_stat),
        .o_q_push (q_push),
        .o_seq    (front_seq)
    );

    // Decouples classification from byte-serial output
    jsesc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_seq   (front_seq),
        .i_pop   (q_pop),
        .o_seq   (q_seq),
        .o_stat  (q_stat)
    );

    // Walk the bytes of the head character into the output register
    jsesc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_seq    (q_seq),
        .i_q_stat (q_stat),
        .o_q_pop  (q_pop),
        .empty    (empty),
        .pop      (pop),
        .o_out    (o_out)
    );

endmodule

`default_nettype wire

### rtl/jsesc_checker.sv
// Port-level checks for the JSON string escaper, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module jsesc_props (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  empty,
    input  wire                  pop,
    input  jsesc_pkg::t_out_req  o_out
);

    // Reset leaves nothing to read
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("output not empty after reset");

    // Rest of a character is already queued: no gap inside a run
    a_run_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !o_out.last_byte) |=> !empty)
        else $error("gap inside a character's byte run");

    // A stalled byte holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out)))
        else $error("output changed while stalled");

    // A question mark only ever stands alone
    a_qmark_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out.out_byte == jsesc_pkg::CH_QMARK) |-> o_out.last_byte)
        else $error("question mark not last in run");

    // A UTF-8 lead byte always has continuation bytes after it
    a_lead_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out.out_byte[7:6] == 2'b11) |-> !o_out.last_byte)
        else $error("UTF-8 lead byte marked last");

endmodule

bind json_string_escape_utf8 jsesc_props u_jsesc_props (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .empty   (empty),
    .pop     (pop),
    .o_out   (o_out)
);

`default_nettype wire
